[design/bce_pkg.sv]
// Shared widths, curve table, register map and transfer types of the charge estimator.
package bce_pkg;

  localparam int MvW         = 13;
  localparam int FsW         = 16;
  localparam int PctW        = 7;
  localparam int QuoW        = 16;
  localparam int NumW        = MvW + FsW;
  localparam int DenW        = MvW;
  localparam int CfgIdxW     = 2;
  localparam int CfgDataW    = 16;
  localparam int QueueDepth  = 2;
  localparam int CurvePoints = 12;

  localparam logic [FsW-1:0] DefaultFullScale = FsW'(200);
  localparam logic           ModeReset        = 1'b0;
  localparam logic [MvW-1:0] VminReset        = MvW'(2000);
  localparam logic [MvW-1:0] VmaxReset        = MvW'(3000);
  localparam logic [FsW-1:0] FullScaleReset   = FsW'(200);

  localparam logic [MvW-1:0] CellMv [CurvePoints] = '{
    MvW'(3000), MvW'(2950), MvW'(2900), MvW'(2850), MvW'(2800), MvW'(2750),
    MvW'(2700), MvW'(2650), MvW'(2600), MvW'(2500), MvW'(2400), MvW'(2200)
  };

  localparam logic [PctW-1:0] CellPct [CurvePoints] = '{
    PctW'(100), PctW'(95), PctW'(85), PctW'(70), PctW'(55), PctW'(42),
    PctW'(30),  PctW'(20), PctW'(12), PctW'(6),  PctW'(3),  PctW'(0)
  };

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MODE,
    CFG_VMIN,
    CFG_VMAX,
    CFG_FULL_SCALE
  } cfg_idx_e;

  typedef struct packed {
    logic           mode;
    logic [MvW-1:0] vmin;
    logic [MvW-1:0] vmax;
    logic [FsW-1:0] full_scale;
  } cfg_t;

  typedef struct packed {
    logic [MvW-1:0]  mv;
    logic [NumW-1:0] num;
    logic [DenW-1:0] den;
  } job_t;

endpackage

[design/bce_front.sv]
// Front end: classifies each sample, interpolates the cell curve and forms the division job.
module bce_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  logic [bce_pkg::MvW-1:0]   sample_mv_i,
  input  bce_pkg::cfg_t             cfg_i,
  output logic                      valid_o,
  output bce_pkg::job_t             job_o
);

  localparam int SegW       = 8;
  localparam int DpW        = 4;
  localparam int NW         = 10;
  localparam int RecipW     = 11;
  localparam int ProdW      = NW + RecipW;
  localparam int RecipShift = 16;
  localparam int RecipMul   = 1311;
  localparam int SpanMid    = 100;
  localparam int SpanWide   = 200;
  localparam int PctScale   = 100;

  typedef enum logic [1:0] {
    OP_CELL,
    OP_DIV,
    OP_ZERO,
    OP_FULL
  } op_e;

  logic                         f1_valid_q;
  logic [bce_pkg::MvW-1:0]      f1_mv_q;
  op_e                          f1_op_q,   f1_op_d;
  logic [bce_pkg::PctW-1:0]     f1_base_q, f1_base_d;
  logic [NW-1:0]                f1_n_q,    f1_n_d;
  logic [bce_pkg::MvW-1:0]      f1_diff_q;
  logic [bce_pkg::MvW-1:0]      f1_span_q;

  logic                         f2_valid_q;
  logic [bce_pkg::MvW-1:0]      f2_mv_q;
  op_e                          f2_op_q;
  logic [bce_pkg::PctW-1:0]     f2_pct_q,  f2_pct_d;
  logic [bce_pkg::MvW-1:0]      f2_diff_q;
  logic [bce_pkg::MvW-1:0]      f2_span_q;

  logic [ProdW-1:0]             recip_prod;
  logic [bce_pkg::FsW-1:0]      fs_eff;

  always_comb begin : cell_search
    logic              found;
    logic [SegW-1:0]   seg;
    logic [DpW-1:0]    dpct;
    logic [SegW+DpW-1:0] prod;
    found     = 1'b0;
    seg       = '0;
    dpct      = '0;
    prod      = '0;
    f1_base_d = '0;
    f1_n_d    = '0;
    if (sample_mv_i >= bce_pkg::CellMv[0]) begin
      found     = 1'b1;
      f1_base_d = bce_pkg::CellPct[0];
    end
    for (int k = 1; k < bce_pkg::CurvePoints; k++) begin
      seg  = SegW'(sample_mv_i - bce_pkg::CellMv[k]);
      dpct = DpW'(bce_pkg::CellPct[k-1] - bce_pkg::CellPct[k]);
      prod = (SegW+DpW)'(dpct) * (SegW+DpW)'(seg);
      if (!found && sample_mv_i >= bce_pkg::CellMv[k]) begin
        found     = 1'b1;
        f1_base_d = bce_pkg::CellPct[k];
        if (bce_pkg::CellMv[k-1] - bce_pkg::CellMv[k] == bce_pkg::MvW'(SpanWide)) begin
          f1_n_d = NW'(prod >> 2);
        end else if (bce_pkg::CellMv[k-1] - bce_pkg::CellMv[k] ==
                     bce_pkg::MvW'(SpanMid)) begin
          f1_n_d = NW'(prod >> 1);
        end else begin
          f1_n_d = NW'(prod);
        end
      end
    end
  end

  always_comb begin
    priority if (cfg_i.mode) begin
      f1_op_d = OP_CELL;
    end else if (sample_mv_i < cfg_i.vmin) begin
      f1_op_d = OP_ZERO;
    end else if (sample_mv_i > cfg_i.vmax) begin
      f1_op_d = OP_FULL;
    end else if (cfg_i.vmax == cfg_i.vmin) begin
      f1_op_d = OP_FULL;
    end else begin
      f1_op_d = OP_DIV;
    end
  end

  assign recip_prod = ProdW'(f1_n_q) * ProdW'(RecipMul);
  assign f2_pct_d   = f1_base_q + bce_pkg::PctW'(recip_prod[ProdW-1:RecipShift]);

  assign fs_eff = (cfg_i.full_scale == '0) ? bce_pkg::DefaultFullScale : cfg_i.full_scale;

  always_comb begin
    job_o.mv = f2_mv_q;
    unique case (f2_op_q)
      OP_CELL: begin
        job_o.num = bce_pkg::NumW'(f2_pct_q) * bce_pkg::NumW'(fs_eff);
        job_o.den = bce_pkg::DenW'(PctScale);
      end
      OP_DIV: begin
        job_o.num = bce_pkg::NumW'(f2_diff_q) * bce_pkg::NumW'(fs_eff);
        job_o.den = f2_span_q;
      end
      OP_ZERO: begin
        job_o.num = '0;
        job_o.den = bce_pkg::DenW'(1);
      end
      OP_FULL: begin
        job_o.num = bce_pkg::NumW'(fs_eff);
        job_o.den = bce_pkg::DenW'(1);
      end
    endcase
  end

  assign valid_o = f2_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_valid_q <= 1'b0;
      f2_valid_q <= 1'b0;
    end else begin
      f1_valid_q <= valid_i;
      f2_valid_q <= f1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    f1_mv_q   <= sample_mv_i;
    f1_op_q   <= f1_op_d;
    f1_base_q <= f1_base_d;
    f1_n_q    <= f1_n_d;
    f1_diff_q <= sample_mv_i - cfg_i.vmin;
    f1_span_q <= cfg_i.vmax - cfg_i.vmin;
    f2_mv_q   <= f1_mv_q;
    f2_op_q   <= f1_op_q;
    f2_pct_q  <= f2_pct_d;
    f2_diff_q <= f1_diff_q;
    f2_span_q <= f1_span_q;
  end

endmodule

[design/bce_queue.sv]
// Short request queue between the front end and the divider.
module bce_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  bce_pkg::job_t push_data_i,
  input  logic          pop_i,
  output logic          valid_o,
  output bce_pkg::job_t pop_data_o,
  output logic          full_o
);

  localparam int PtrW = $clog2(bce_pkg::QueueDepth);
  localparam int CntW = $clog2(bce_pkg::QueueDepth + 1);

  bce_pkg::job_t  mem_q [bce_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q,  count_d;
  logic            do_push;
  logic            do_pop;

  assign full_o     = (count_q == CntW'(bce_pkg::QueueDepth));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? PtrW'(wr_ptr_q + 1'b1) : wr_ptr_q;
    rd_ptr_d = do_pop  ? PtrW'(rd_ptr_q + 1'b1) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = CntW'(count_q + 1'b1);
    end else if (do_pop && !do_push) begin
      count_d = CntW'(count_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[design/bce_div.sv]
// Back end: pipelined restoring divider, one quotient bit per stage.
module bce_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  bce_pkg::job_t            job_i,
  output logic                     valid_o,
  output logic [bce_pkg::MvW-1:0]  echo_mv_o,
  output logic [bce_pkg::QuoW-1:0] quotient_o
);

  localparam int Stages = bce_pkg::QuoW;

  logic                      vld_q [Stages+1];
  logic [bce_pkg::MvW-1:0]   mv_q  [Stages+1];
  logic [bce_pkg::NumW-1:0]  rem_q [Stages+1];
  logic [bce_pkg::DenW-1:0]  den_q [Stages+1];
  logic [bce_pkg::QuoW-1:0]  quo_q [Stages+1];
  logic [bce_pkg::NumW-1:0]  rem_d [Stages];
  logic [bce_pkg::QuoW-1:0]  quo_d [Stages];

  always_comb begin
    for (int s = 0; s < Stages; s++) begin
      logic [bce_pkg::NumW-1:0] sub;
      logic                     ge;
      sub = bce_pkg::NumW'(den_q[s]) << (Stages - 1 - s);
      ge  = (rem_q[s] >= sub);
      rem_d[s] = ge ? bce_pkg::NumW'(rem_q[s] - sub) : rem_q[s];
      quo_d[s] = {quo_q[s][bce_pkg::QuoW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= Stages; s++) begin
        vld_q[s] <= 1'b0;
      end
    end else begin
      vld_q[0] <= valid_i;
      for (int s = 0; s < Stages; s++) begin
        vld_q[s+1] <= vld_q[s];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mv_q[0]  <= job_i.mv;
    rem_q[0] <= job_i.num;
    den_q[0] <= job_i.den;
    quo_q[0] <= '0;
    for (int s = 0; s < Stages; s++) begin
      mv_q[s+1]  <= mv_q[s];
      rem_q[s+1] <= rem_d[s];
      den_q[s+1] <= den_q[s];
      quo_q[s+1] <= quo_d[s];
    end
  end

  assign valid_o    = vld_q[Stages];
  assign echo_mv_o  = mv_q[Stages];
  assign quotient_o = quo_q[Stages];

endmodule

[design/battery_charge_estimator_unit.sv]
// Battery charge estimator: top level with configuration registers, front end, queue, divider.
//
// Usage:
//   Request channel: drive sample_mv_i and raise start; the request is taken at a rising
//   edge where start is high and busy is low. One request may be taken every cycle.
//   Result channel: valid_o is high for exactly one cycle with echo_mv_o and charge_o.
//   The receiver cannot stall; results leave in request order, one per request.
//   Path: a taken request passes 2 front stages, 1 queue slot, 1 divider load and 16
//   divider stages, in that order, before valid_o goes high with its result.
//   Throughput: one request per cycle; the 16-stage divider, one quotient bit per stage,
//   sets the latency, and busy rises only if the two-entry queue fills.
//   Configuration: cfg_we_i, cfg_idx_i and cfg_wdata_i write curve_mode, voltage_min_mv,
//   voltage_max_mv and full_scale (indexes 0 to 3) at the rising edge; write only while
//   no request is in flight.
//   Reset: rst_ni clears all pipeline valids and the queue, and loads the registers with
//   linear mode, 2000 mV, 3000 mV and a full scale of 200.
module battery_charge_estimator_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [bce_pkg::MvW-1:0]      sample_mv_i,
  input  logic                         cfg_we_i,
  input  logic [bce_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bce_pkg::CfgDataW-1:0] cfg_wdata_i,
  output logic                         valid_o,
  output logic [bce_pkg::MvW-1:0]      echo_mv_o,
  output logic [bce_pkg::FsW-1:0]      charge_o
);

  bce_pkg::cfg_t cfg_q;
  bce_pkg::job_t front_job;
  bce_pkg::job_t queue_job;
  logic          front_valid;
  logic          queue_valid;
  logic          queue_full;
  logic          accept;

  assign busy   = queue_full;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode       <= bce_pkg::ModeReset;
      cfg_q.vmin       <= bce_pkg::VminReset;
      cfg_q.vmax       <= bce_pkg::VmaxReset;
      cfg_q.full_scale <= bce_pkg::FullScaleReset;
    end else if (cfg_we_i) begin
      unique case (bce_pkg::cfg_idx_e'(cfg_idx_i))
        bce_pkg::CFG_MODE:       cfg_q.mode       <= cfg_wdata_i[0];
        bce_pkg::CFG_VMIN:       cfg_q.vmin       <= cfg_wdata_i[bce_pkg::MvW-1:0];
        bce_pkg::CFG_VMAX:       cfg_q.vmax       <= cfg_wdata_i[bce_pkg::MvW-1:0];
        bce_pkg::CFG_FULL_SCALE: cfg_q.full_scale <= cfg_wdata_i[bce_pkg::FsW-1:0];
      endcase
    end
  end

  bce_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (accept),
    .sample_mv_i (sample_mv_i),
    .cfg_i       (cfg_q),
    .valid_o     (front_valid),
    .job_o       (front_job)
  );

  bce_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (front_valid),
    .push_data_i (front_job),
    .pop_i       (queue_valid),
    .valid_o     (queue_valid),
    .pop_data_o  (queue_job),
    .full_o      (queue_full)
  );

  bce_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (queue_valid),
    .job_i      (queue_job),
    .valid_o    (valid_o),
    .echo_mv_o  (echo_mv_o),
    .quotient_o (charge_o)
  );

endmodule

[tb/sv/charge_checker.sv]
`timescale 1ns / 100ps
// Checker for the charge estimator: tracks register writes, predicts each reading and compares.
module charge_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  input  logic                         busy,
  input  logic [bce_pkg::MvW-1:0]      sample_mv_i,
  input  logic                         cfg_we_i,
  input  logic [bce_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bce_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                         valid_o,
  input  logic [bce_pkg::MvW-1:0]      echo_mv_o,
  input  logic [bce_pkg::FsW-1:0]      charge_o,
  output int                           mismatch_count,
  output int                           readings_pending
);

  localparam int KneeCount = 12;
  localparam int unsigned FallbackFullScale = 200;

  localparam int unsigned KneeMv [KneeCount] = '{
    3000, 2950, 2900, 2850, 2800, 2750, 2700, 2650, 2600, 2500, 2400, 2200
  };
  localparam int unsigned KneePct [KneeCount] = '{
    100, 95, 85, 70, 55, 42, 30, 20, 12, 6, 3, 0
  };

  typedef struct packed {
    logic [bce_pkg::MvW-1:0] echo_mv;
    logic [bce_pkg::FsW-1:0] charge;
  } reading_t;

  bce_pkg::cfg_t settings;
  reading_t      expected_readings [$];
  reading_t      want;
  int            fault_tally;

  function automatic int unsigned cell_curve_pct(int unsigned mv);
    if (mv >= KneeMv[0]) return KneePct[0];
    for (int k = 1; k < KneeCount; k++) begin
      if (mv >= KneeMv[k]) begin
        return KneePct[k] + ((KneePct[k-1] - KneePct[k]) * (mv - KneeMv[k]))
               / (KneeMv[k-1] - KneeMv[k]);
      end
    end
    return 0;
  endfunction

  function automatic reading_t estimate_charge(bce_pkg::cfg_t s,
                                               logic [bce_pkg::MvW-1:0] mv);
    int unsigned fs;
    int unsigned v;
    int unsigned lo;
    int unsigned hi;
    int unsigned level;
    reading_t    r;
    fs = (s.full_scale == '0) ? FallbackFullScale : int'(s.full_scale);
    v  = mv;
    lo = s.vmin;
    hi = s.vmax;
    if (s.mode) begin
      level = (cell_curve_pct(v) * fs) / 100;
    end else if (v < lo) begin
      level = 0;
    end else if (v > hi) begin
      level = fs;
    end else if (hi == lo) begin
      level = fs;
    end else begin
      level = ((v - lo) * fs) / (hi - lo);
    end
    r.echo_mv = mv;
    r.charge  = bce_pkg::FsW'(level);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settings = '{mode: 1'b0, vmin: bce_pkg::MvW'(2000), vmax: bce_pkg::MvW'(3000),
                   full_scale: bce_pkg::FsW'(200)};
      expected_readings.delete();
      fault_tally = 0;
      mismatch_count   <= 0;
      readings_pending <= 0;
    end else begin
      if (cfg_we_i) begin
        case (bce_pkg::cfg_idx_e'(cfg_idx_i))
          bce_pkg::CFG_MODE:       settings.mode       = cfg_wdata_i[0];
          bce_pkg::CFG_VMIN:       settings.vmin       = cfg_wdata_i[bce_pkg::MvW-1:0];
          bce_pkg::CFG_VMAX:       settings.vmax       = cfg_wdata_i[bce_pkg::MvW-1:0];
          bce_pkg::CFG_FULL_SCALE: settings.full_scale = cfg_wdata_i[bce_pkg::FsW-1:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        expected_readings.push_back(estimate_charge(settings, sample_mv_i));
      end
      if (valid_o) begin
        if (expected_readings.size() == 0) begin
          $error("unexpected result: echo_mv %0d charge %0d", echo_mv_o, charge_o);
          fault_tally++;
        end else begin
          want = expected_readings.pop_front();
          if (echo_mv_o !== want.echo_mv) begin
            $error("echo_mv: expected %0d, actual %0d", want.echo_mv, echo_mv_o);
            fault_tally++;
          end
          if (charge_o !== want.charge) begin
            $error("charge: expected %0d, actual %0d", want.charge, charge_o);
            fault_tally++;
          end
        end
      end
      mismatch_count   <= fault_tally;
      readings_pending <= expected_readings.size();
    end
  end

endmodule

[tb/sv/battery_charge_estimator_unit_test.sv]
`timescale 1ns / 100ps
// Testbench top for the charge estimator: clock, reset, register settings and sample stimulus.
module battery_charge_estimator_unit_test;

  localparam int CycleLimit    = 200000;
  localparam int RandomPhases  = 10;
  localparam int ItemsPerPhase = 65;
  localparam int SettleCycles  = 30;
  localparam int MvMax         = 8191;

  logic                         clk_i;
  logic                         rst_ni      = 1'b0;
  logic                         start       = 1'b0;
  logic                         busy;
  logic [bce_pkg::MvW-1:0]      sample_mv_i = '0;
  logic                         cfg_we_i    = 1'b0;
  logic [bce_pkg::CfgIdxW-1:0]  cfg_idx_i   = '0;
  logic [bce_pkg::CfgDataW-1:0] cfg_wdata_i = '0;
  logic                         valid_o;
  logic [bce_pkg::MvW-1:0]      echo_mv_o;
  logic [bce_pkg::FsW-1:0]      charge_o;
  int                           mismatch_count;
  int                           readings_pending;
  int                           cycle_count = 0;
  int                           cur_vmin = 2000;
  int                           cur_vmax = 3000;

  battery_charge_estimator_unit u_dut (.*);

  charge_checker u_checker (.*);

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("battery_charge_estimator_unit_test NOT OK");
      $finish;
    end
  end

  task automatic send_sample(input logic [bce_pkg::MvW-1:0] mv);
    start       <= 1'b1;
    sample_mv_i <= mv;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic hold_off(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic drain_requests();
    start <= 1'b0;
    do @(posedge clk_i); while (readings_pending != 0);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_register(input bce_pkg::cfg_idx_e idx,
                                input logic [bce_pkg::CfgDataW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
  endtask

  task automatic apply_settings(input logic mode, input int vmin, input int vmax,
                                input int fs);
    logic [bce_pkg::CfgDataW-1:0] word;
    drain_requests();
    word    = bce_pkg::CfgDataW'($urandom);
    word[0] = mode;
    write_register(bce_pkg::CFG_MODE, word);
    word         = bce_pkg::CfgDataW'($urandom);
    word[bce_pkg::MvW-1:0] = bce_pkg::MvW'(vmin);
    write_register(bce_pkg::CFG_VMIN, word);
    word         = bce_pkg::CfgDataW'($urandom);
    word[bce_pkg::MvW-1:0] = bce_pkg::MvW'(vmax);
    write_register(bce_pkg::CFG_VMAX, word);
    write_register(bce_pkg::CFG_FULL_SCALE, bce_pkg::FsW'(fs));
    cfg_we_i <= 1'b0;
    cur_vmin = vmin;
    cur_vmax = vmax;
  endtask

  function automatic logic [bce_pkg::MvW-1:0] pick_sample();
    int v;
    case ($urandom_range(0, 3))
      0:       v = $urandom_range(0, MvMax);
      1:       v = $urandom_range(2150, 3050);
      2:       v = ($urandom_range(0, 1) ? cur_vmin : cur_vmax) + $urandom_range(0, 8) - 4;
      default: v = $urandom_range(1500, 3500);
    endcase
    if (v < 0) v = 0;
    if (v > MvMax) v = MvMax;
    return bce_pkg::MvW'(v);
  endfunction

  initial begin
    int vmin;
    int vmax;
    int fs;
    int burst_left;
    int gap;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_sample(0);
    send_sample(1999);
    send_sample(2000);
    send_sample(2001);
    send_sample(2500);
    send_sample(3000);
    send_sample(3001);
    send_sample(MvMax);

    apply_settings(1'b1, 2000, 3000, 65535);
    send_sample(MvMax);
    send_sample(3000);
    send_sample(2999);
    send_sample(2975);
    send_sample(2200);
    send_sample(2199);
    send_sample(2450);
    send_sample(0);

    apply_settings(1'b0, 2500, 2500, 0);
    send_sample(2499);
    send_sample(2500);
    send_sample(2501);

    apply_settings(1'b0, 3000, 1000, 1);
    send_sample(999);
    send_sample(2000);
    send_sample(3001);

    apply_settings(1'b0, 0, MvMax, 65535);
    send_sample(MvMax);
    send_sample(4095);

    for (int phase = 0; phase < RandomPhases; phase++) begin
      case ($urandom_range(0, 5))
        0: begin
          vmin = 0;
          vmax = MvMax;
        end
        1: begin
          vmin = $urandom_range(0, MvMax);
          vmax = vmin;
        end
        2: begin
          vmax = $urandom_range(0, 4000);
          vmin = $urandom_range(vmax + 1, MvMax);
        end
        default: begin
          vmin = $urandom_range(1000, 3000);
          vmax = $urandom_range(vmin, 4500);
        end
      endcase
      case ($urandom_range(0, 4))
        0:       fs = 0;
        1:       fs = 65535;
        2:       fs = $urandom_range(1, 10);
        default: fs = $urandom_range(0, 65535);
      endcase
      apply_settings(1'(phase % 2), vmin, vmax, fs);
      burst_left = 0;
      for (int n = 0; n < ItemsPerPhase; n++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap = ($urandom_range(0, 3) == 0 || phase == 3) ? 0 : $urandom_range(1, 6);
          if (gap > 0) hold_off(gap);
        end
        send_sample(pick_sample());
        burst_left--;
      end
    end

    drain_requests();
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatch_count == 0 && readings_pending == 0) begin
      $display("battery_charge_estimator_unit_test OK");
    end else begin
      $display("battery_charge_estimator_unit_test NOT OK");
    end
    $finish;
  end

endmodule
